>>> design/neighbour_quadrant_nearest_core_defines.svh
// Assertion macros for the neighbour quadrant nearest-peer block.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef NEIGHBOUR_QUADRANT_NEAREST_CORE_DEFINES_SVH
`define NEIGHBOUR_QUADRANT_NEAREST_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NQN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define NQN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define NQN_ASSERT_IMP(label, clk, rst, ante, cons)
`define NQN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/nqn_pkg.sv
// Package for the neighbour quadrant nearest-peer block: payload types,
// constants and the CORDIC angle table. No dependencies.
`default_nettype none
package nqn_pkg;
   localparam int NEIGHBOURS = 16;
   localparam int SECTORS    = 4;
   localparam int IDX_W      = $clog2(NEIGHBOURS);
   localparam int CORDIC_N   = 14;

   localparam logic [0:0] OP_STORE = 1'b0;
   localparam logic [0:0] OP_EVAL  = 1'b1;

   localparam logic [0:0] CSR_OWN_ID = 1'b0;
   localparam logic [0:0] CSR_RANGE  = 1'b1;

   localparam logic signed [16:0] MARGIN = 17'sd1229;

   typedef struct packed {
      logic              opcode;
      logic [7:0]        neighbour_id;
      logic signed [15:0] item_x;
      logic signed [15:0] item_y;
      logic [15:0]       item_heading;
   } req_type;

   typedef struct packed {
      logic [1:0] quadrant;
      logic [7:0] nearest_distance;
      logic [7:0] nearest_heading;
      logic       last_of_frame;
   } rsp_type;

   function automatic logic [13:0] atan_entry(input logic [3:0] i);
      logic [13:0] r;
      case (i)
         4'd0:  r = 14'd8192;
         4'd1:  r = 14'd4836;
         4'd2:  r = 14'd2555;
         4'd3:  r = 14'd1297;
         4'd4:  r = 14'd651;
         4'd5:  r = 14'd326;
         4'd6:  r = 14'd163;
         4'd7:  r = 14'd81;
         4'd8:  r = 14'd41;
         4'd9:  r = 14'd20;
         4'd10: r = 14'd10;
         4'd11: r = 14'd5;
         4'd12: r = 14'd3;
         4'd13: r = 14'd1;
         default: r = 14'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

>>> design/neighbour_quadrant_nearest_core.sv
// Top level of the neighbour quadrant nearest-peer block: peer table,
// sequencer and one shared CORDIC / root / divide datapath. Uses nqn_pkg.
//
//  channel | ports                         | direction
//  request | req_valid, req_stall, req_data | in
//  result  | rsp_valid, rsp_stall, rsp_data | out
//  csr     | csr_we, csr_index, csr_wdata   | in
//
// A store request is written to the peer table on acceptance. An evaluation runs the
// offset rotation, then for each live peer fetch, check, CORDIC vectoring, square root,
// divide and update, and for each skipped peer only fetch and check, all on the single
// shared shift-add unit; then four results, one per cycle as the result side takes them.
// Reset clears the alive bits, prior heading and state and sets own id to 0 and range to
// 8192; the peer table contents are undefined until written. A stalled result holds the sequencer.
`default_nettype none
`include "neighbour_quadrant_nearest_core_defines.svh"
module neighbour_quadrant_nearest_core
   import nqn_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);
   localparam logic [3:0] ST_IDLE = 4'd0, ST_ROT = 4'd1, ST_OFS = 4'd2, ST_FETCH = 4'd3,
      ST_CHECK = 4'd4, ST_VEC = 4'd5, ST_SQRT = 4'd6, ST_DIV = 4'd7, ST_UPD = 4'd8,
      ST_OUT = 4'd9, ST_PRE = 4'd10, ST_OFS2 = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [7:0] own_id_ff;
   logic [14:0] range_ff;
   logic [NEIGHBOURS-1:0] alive_ff;
   logic [15:0] prior_ff;

   logic signed [15:0] mem_x [NEIGHBOURS];
   logic signed [15:0] mem_y [NEIGHBOURS];
   logic [15:0] mem_h [NEIGHBOURS];
   logic signed [15:0] rd_x_ff, rd_y_ff;
   logic [15:0] rd_h_ff;

   req_type req_ff;
   logic [IDX_W:0] idx_ff;
   logic [4:0] step_ff;
   // shared CORDIC registers; 40 bits hold the scaled vectors with growth
   logic signed [39:0] cx_ff, cy_ff;
   logic signed [17:0] cz_ff;
   logic signed [17:0] px_ff, py_ff;
   logic signed [17:0] dx_ff, dy_ff;
   logic [35:0] rem_ff, root_ff;
   logic [15:0] dist_ff;
   logic [15:0] bear_ff;
   logic [23:0] num_ff;
   logic [7:0] quo_ff;
   logic [7:0] best_d_ff [SECTORS];
   logic [7:0] best_h_ff [SECTORS];
   logic [1:0] sec_ff;
   logic [14:0] rng;

   assign rng = (range_ff == 15'd0) ? 15'd1 : range_ff;
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= 8'd0;
         range_ff  <= 15'd8192;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ID: own_id_ff <= csr_wdata[7:0];
            CSR_RANGE:  range_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic store_ok;
   assign store_ok = req_valid && !req_stall && (req_data.opcode == OP_STORE) &&
                     (req_data.neighbour_id >= 8'd1) &&
                     ({1'b0, req_data.neighbour_id} <= 9'(NEIGHBOURS));
   logic [IDX_W-1:0] wr_idx;
   assign wr_idx = IDX_W'(req_data.neighbour_id - 8'd1);

   always_ff @(posedge clock) begin
      if (store_ok) begin
         mem_x[wr_idx] <= req_data.item_x;
         mem_y[wr_idx] <= req_data.item_y;
         mem_h[wr_idx] <= req_data.item_heading;
      end
      rd_x_ff <= mem_x[idx_ff[IDX_W-1:0]];
      rd_y_ff <= mem_y[idx_ff[IDX_W-1:0]];
      rd_h_ff <= mem_h[idx_ff[IDX_W-1:0]];
   end

   // one CORDIC micro-rotation, shared by rotation and vectoring
   logic [3:0] it;
   logic signed [39:0] sh_x, sh_y;
   logic up;
   // Vectoring spends its first step loading the vector, so its stage index lags by one.
   assign it = (state_ff == ST_VEC) ? 4'(step_ff - 5'd1) : step_ff[3:0];
   assign sh_x = cx_ff >>> it;
   assign sh_y = cy_ff >>> it;
   assign up = (state_ff == ST_ROT) ? (cz_ff >= 0) : (cy_ff > 0);
   logic signed [17:0] at;
   assign at = 18'(atan_entry(it));

   // sector and divide helpers
   logic signed [15:0] local_b;
   logic [1:0] sec_sel;
   assign local_b = bear_ff - prior_ff;
   always_comb begin
      if (local_b >= -16'sd8192 && local_b < 16'sd8192) sec_sel = 2'd0;
      else if (local_b >= 16'sd8192 && local_b < 16'sd24576) sec_sel = 2'd1;
      else if (local_b >= -16'sd24576 && local_b < -16'sd8192) sec_sel = 2'd3;
      else sec_sel = 2'd2;
   end

   logic [35:0] trial;
   assign trial = root_ff | (36'd1 << (6'd32 - {step_ff, 1'b0}));
   logic signed [35:0] dd;
   assign dd = 36'(dx_ff * dx_ff) + 36'(dy_ff * dy_ff);
   logic [23:0] div_sh;
   assign div_sh = {rem_ff[22:0], num_ff[23]};
   logic signed [39:0] oxm, oym;
   assign oxm = signed'(cx_ff[23:0]) * 16'sd19898 + 40'sd4194304;
   assign oym = signed'(cy_ff[23:0]) * 16'sd19898 + 40'sd4194304;
   logic signed [17:0] d_clamp;
   assign d_clamp = 18'(signed'({1'b0, root_ff[17:0]})) - 18'(MARGIN);
   logic [16:0] prod_h;
   assign prod_h = 17'(({8'd0, rd_h_ff} * 24'd255) >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         alive_ff <= '0;
         prior_ff <= 16'd0;
      end else begin
         state_ff <= state_in;
         if (store_ok) alive_ff[wr_idx] <= 1'b1;
         if (state_ff == ST_OUT && !rsp_stall && sec_ff == 2'd3) prior_ff <= req_ff.item_heading;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && req_data.opcode == OP_EVAL) state_in = ST_PRE;
         ST_PRE: state_in = ST_ROT;
         ST_ROT: if (step_ff == 5'd13) state_in = ST_OFS;
         ST_OFS: state_in = ST_OFS2;
         ST_OFS2: state_in = ST_FETCH;
         ST_FETCH: state_in = (idx_ff == (IDX_W+1)'(NEIGHBOURS)) ? ST_OUT : ST_CHECK;
         ST_CHECK: begin
            if (alive_ff[idx_ff[IDX_W-1:0]] && rd_x_ff > 0 &&
                (8'(idx_ff) + 8'd1) != own_id_ff) state_in = ST_VEC;
            else state_in = ST_FETCH;
         end
         ST_VEC: if (step_ff == 5'd14) state_in = ST_SQRT;
         ST_SQRT: if (step_ff == 5'd17) state_in = ST_DIV;
         ST_DIV: if (step_ff == 5'd24) state_in = ST_UPD;
         ST_UPD: state_in = ST_FETCH;
         ST_OUT: if (!rsp_stall && sec_ff == 2'd3) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            req_ff <= req_data;
            step_ff <= 5'd0;
         end
         ST_PRE: begin
            // fold the angle into the right half-plane first
            if (prior_ff >= 16'h4000 && prior_ff < 16'hC000) begin
               cx_ff <= 40'sd94464; cy_ff <= -40'sd41984;
               cz_ff <= 18'(signed'(16'(prior_ff + 16'h8000)));
            end else begin
               cx_ff <= -40'sd94464; cy_ff <= 40'sd41984;
               cz_ff <= 18'(signed'(prior_ff));
            end
            step_ff <= 5'd0;
            sec_ff <= 2'd0;
            for (int k = 0; k < SECTORS; k++) begin
               best_d_ff[k] <= 8'd255; best_h_ff[k] <= 8'd0;
            end
         end
         ST_ROT: begin
            cx_ff <= up ? cx_ff - sh_y : cx_ff + sh_y;
            cy_ff <= up ? cy_ff + sh_x : cy_ff - sh_x;
            cz_ff <= up ? cz_ff - at : cz_ff + at;
            step_ff <= step_ff + 5'd1;
         end
         ST_OFS: begin
            cx_ff <= oxm >>> 23;
            cy_ff <= oym >>> 23;
         end
         ST_OFS2: begin
            px_ff <= 18'(req_ff.item_x) + 18'(cx_ff);
            py_ff <= 18'(req_ff.item_y) + 18'(cy_ff);
            idx_ff <= '0;
         end
         ST_FETCH: ;
         ST_CHECK: begin
            dx_ff <= 18'(rd_x_ff) - px_ff;
            dy_ff <= 18'(rd_y_ff) - py_ff;
            step_ff <= 5'd0;
            if (!(alive_ff[idx_ff[IDX_W-1:0]] && rd_x_ff > 0 &&
                  (8'(idx_ff) + 8'd1) != own_id_ff)) idx_ff <= idx_ff + 1'b1;
         end
         ST_VEC: begin
            if (step_ff == 5'd0) begin
               if (dx_ff < 0 && dy_ff >= 0) begin
                  cx_ff <= 40'(dy_ff) <<< 8; cy_ff <= -(40'(dx_ff) <<< 8); cz_ff <= 18'sd16384;
               end else if (dx_ff < 0) begin
                  cx_ff <= -(40'(dy_ff) <<< 8); cy_ff <= 40'(dx_ff) <<< 8; cz_ff <= -18'sd16384;
               end else begin
                  cx_ff <= 40'(dx_ff) <<< 8; cy_ff <= 40'(dy_ff) <<< 8; cz_ff <= '0;
               end
               rem_ff <= 36'(dd); root_ff <= '0;
               step_ff <= 5'd1;
            end else begin
               cx_ff <= up ? cx_ff + sh_y : cx_ff - sh_y;
               cy_ff <= up ? cy_ff - sh_x : cy_ff + sh_x;
               cz_ff <= up ? cz_ff + at : cz_ff - at;
               if (step_ff == 5'd14) begin
                  bear_ff <= (dx_ff == 0 && dy_ff == 0) ? 16'd0 :
                             16'(up ? cz_ff + at : cz_ff - at);
                  step_ff <= 5'd0;
               end else step_ff <= step_ff + 5'd1;
            end
         end
         ST_SQRT: begin
            // restoring square root, one result bit a step
            if (step_ff < 5'd17) begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  root_ff <= (root_ff >> 1) | (36'd1 << (6'd32 - {step_ff, 1'b0}));
               end else root_ff <= root_ff >> 1;
               step_ff <= step_ff + 5'd1;
            end else begin
               if (d_clamp < 0) dist_ff <= 16'd0;
               else if (d_clamp > 18'(rng)) dist_ff <= 16'(rng);
               else dist_ff <= 16'(d_clamp);
               step_ff <= 5'd0;
            end
         end
         ST_DIV: begin
            if (step_ff == 5'd0) begin
               num_ff <= 24'(dist_ff) * 24'd255; rem_ff <= '0; quo_ff <= '0;
               sec_ff <= sec_sel;
            end else begin
               if (div_sh >= 24'(rng)) begin
                  rem_ff <= 36'(div_sh - 24'(rng)); quo_ff <= {quo_ff[6:0], 1'b1};
               end else begin
                  rem_ff <= 36'(div_sh); quo_ff <= {quo_ff[6:0], 1'b0};
               end
               num_ff <= num_ff << 1;
            end
            step_ff <= step_ff + 5'd1;
         end
         ST_UPD: begin
            if (quo_ff < best_d_ff[sec_ff]) begin
               best_d_ff[sec_ff] <= quo_ff;
               best_h_ff[sec_ff] <= prod_h[7:0];
            end
            idx_ff <= idx_ff + 1'b1;
            sec_ff <= 2'd0;
         end
         ST_OUT: if (!rsp_stall) sec_ff <= sec_ff + 2'd1;
         default: ;
      endcase
   end

   assign rsp_valid = (state_ff == ST_OUT);
   always_comb begin
      rsp_data.quadrant = sec_ff;
      rsp_data.nearest_distance = best_d_ff[sec_ff];
      rsp_data.nearest_heading = best_h_ff[sec_ff];
      rsp_data.last_of_frame = (sec_ff == 2'd3);
   end

   `NQN_ASSERT_IMP(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall)
   `NQN_ASSERT_IMP(a_out_only, clock, reset, rsp_valid, state_ff == ST_OUT)
   `NQN_ASSERT_NEXT(a_last_done, clock, reset, rsp_valid && !rsp_stall && rsp_data.last_of_frame, state_ff == ST_IDLE)
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the neighbour quadrant nearest-peer block: drives
// store and evaluate requests and checks every sector result. Uses nqn_pkg.
module testbench;
   import nqn_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = CSR_OWN_ID;
   logic [14:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int failures = 0;
   bit running = 1'b0;

   // Model of the block's state.
   logic [7:0]         mdl_own_id;
   logic [14:0]        mdl_range;
   bit                 mdl_alive [NEIGHBOURS];
   logic signed [15:0] mdl_x [NEIGHBOURS];
   logic signed [15:0] mdl_y [NEIGHBOURS];
   logic [15:0]        mdl_heading [NEIGHBOURS];
   logic [15:0]        mdl_prior;

   rsp_type sector_results [$];

   neighbour_quadrant_nearest_core dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v = v - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic longint arctan_step(int i);
      longint t [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      return t[i];
   endfunction

   task automatic rotate_vec(inout longint x, inout longint y, input logic [15:0] ang);
      longint z, nx;
      logic [15:0] a;
      a = ang;
      if (a >= 16'h4000 && a < 16'hC000) begin
         x = -x;
         y = -y;
         a = a + 16'h8000;
      end
      z = longint'($signed(a));
      for (int i = 0; i < 14; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= arctan_step(i);
         end else begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += arctan_step(i);
         end
         x = nx;
      end
   endtask

   function automatic logic [15:0] bearing_of(longint x, longint y);
      longint z, nx, t;
      z = 0;
      if (x == 0 && y == 0) return 16'd0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 16384;
         end else begin
            t = x; x = -y; y = t; z = -16384;
         end
      end
      for (int i = 0; i < 14; i++) begin
         if (y > 0) begin
            nx = x + floor_shift(y, i);
            y = y - floor_shift(x, i);
            z += arctan_step(i);
         end else begin
            nx = x - floor_shift(y, i);
            y = y + floor_shift(x, i);
            z -= arctan_step(i);
         end
         x = nx;
      end
      return z[15:0];
   endfunction

   task automatic predict_request(input req_type r);
      longint ox, oy, px, py, dx, dy, d, rng;
      logic [7:0] best_d [SECTORS];
      logic [7:0] best_h [SECTORS];
      logic signed [15:0] local_b;
      int sec;
      longint db;
      rsp_type res;
      if (r.opcode == OP_STORE) begin
         if (r.neighbour_id >= 1 && r.neighbour_id <= NEIGHBOURS) begin
            mdl_alive[r.neighbour_id - 1] = 1'b1;
            mdl_x[r.neighbour_id - 1] = r.item_x;
            mdl_y[r.neighbour_id - 1] = r.item_y;
            mdl_heading[r.neighbour_id - 1] = r.item_heading;
         end
         return;
      end
      rng = (mdl_range == 0) ? 1 : longint'(mdl_range);
      ox = -369 * 256;
      oy = 164 * 256;
      rotate_vec(ox, oy, mdl_prior);
      ox = floor_shift(ox * 19898 + (64'd1 << 22), 23);
      oy = floor_shift(oy * 19898 + (64'd1 << 22), 23);
      px = longint'(r.item_x) + ox;
      py = longint'(r.item_y) + oy;
      for (int k = 0; k < SECTORS; k++) begin
         best_d[k] = 8'd255;
         best_h[k] = 8'd0;
      end
      for (int i = 0; i < NEIGHBOURS; i++) begin
         if (!mdl_alive[i] || mdl_x[i] <= 0 || (i + 1) == mdl_own_id) continue;
         dx = longint'(mdl_x[i]) - px;
         dy = longint'(mdl_y[i]) - py;
         d = int_sqrt(dx * dx + dy * dy) - 1229;
         if (d < 0) d = 0;
         if (d > rng) d = rng;
         local_b = bearing_of(dx * 256, dy * 256) - mdl_prior;
         if (local_b >= -8192 && local_b < 8192) sec = 0;
         else if (local_b >= 8192 && local_b < 24576) sec = 1;
         else if (local_b >= -24576 && local_b < -8192) sec = 3;
         else sec = 2;
         db = (d * 255) / rng;
         if (db < best_d[sec]) begin
            best_d[sec] = db[7:0];
            best_h[sec] = 8'((longint'(mdl_heading[i]) * 255) >> 16);
         end
      end
      mdl_prior = r.item_heading;
      for (int k = 0; k < SECTORS; k++) begin
         res.quadrant = 2'(k);
         res.nearest_distance = best_d[k];
         res.nearest_heading = best_h[k];
         res.last_of_frame = (k == SECTORS - 1);
         sector_results.push_back(res);
      end
   endtask

   // Result checker and receiver stalls.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sector_results.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            failures++;
         end else begin
            want = sector_results.pop_front();
            if (rsp_data.quadrant !== want.quadrant) begin
               $error("quadrant: expected %0d, got %0d", want.quadrant, rsp_data.quadrant);
               failures++;
            end
            if (rsp_data.nearest_distance !== want.nearest_distance) begin
               $error("nearest_distance: expected %0d, got %0d",
                      want.nearest_distance, rsp_data.nearest_distance);
               failures++;
            end
            if (rsp_data.nearest_heading !== want.nearest_heading) begin
               $error("nearest_heading: expected %0d, got %0d",
                      want.nearest_heading, rsp_data.nearest_heading);
               failures++;
            end
            if (rsp_data.last_of_frame !== want.last_of_frame) begin
               $error("last_of_frame: expected %0d, got %0d",
                      want.last_of_frame, rsp_data.last_of_frame);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= running && ($urandom_range(99) < stall_pct);
   end

   // The request stays valid after acceptance until the next call or a drain,
   // so requests can follow each other with no gap.
   task automatic send_request(input req_type r);
      bit stalled;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      // The stall seen between the falling and the rising edge decides acceptance.
      forever begin
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
         @(negedge clock);
      end
      predict_request(r);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sector_results.size() != 0) @(negedge clock);
      // An in-flight store gives no result, so keep waiting after the queue empties.
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [14:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_OWN_ID) mdl_own_id = value[7:0];
      else mdl_range = value;
   endtask

   function automatic req_type make_store(logic [7:0] id, logic [15:0] x, logic [15:0] y,
                                          logic [15:0] h);
      req_type r;
      r.opcode = OP_STORE;
      r.neighbour_id = id;
      r.item_x = x;
      r.item_y = y;
      r.item_heading = h;
      return r;
   endfunction

   function automatic req_type make_eval(logic [15:0] x, logic [15:0] y, logic [15:0] h);
      req_type r;
      r.opcode = OP_EVAL;
      r.neighbour_id = 8'($urandom);
      r.item_x = x;
      r.item_y = y;
      r.item_heading = h;
      return r;
   endfunction

   task automatic test_empty_and_extremes();
      send_request(make_eval(16'h0000, 16'h0000, 16'h0000));
      send_request(make_store(8'd1, 16'h7FFF, 16'h7FFF, 16'hFFFF));
      send_request(make_store(8'd2, 16'h0001, 16'h8000, 16'h0000));
      send_request(make_store(8'd3, 16'h8000, 16'h0000, 16'h8000));
      send_request(make_store(8'd16, 16'h1000, 16'h1000, 16'h4000));
      send_request(make_store(8'd0, 16'h2000, 16'h0000, 16'h1234));
      send_request(make_store(8'd17, 16'h2000, 16'h0000, 16'h1234));
      send_request(make_store(8'd255, 16'h2000, 16'h0000, 16'h1234));
      send_request(make_eval(16'h8000, 16'h8000, 16'hFFFF));
      send_request(make_eval(16'h7FFF, 16'h7FFF, 16'h8000));
      send_request(make_eval(16'h0000, 16'h0000, 16'h4000));
   endtask

   task automatic test_sectors_and_back_gap();
      // Peers around the unit in every direction, including the back-sector gap.
      send_request(make_store(8'd4, 16'h2000, 16'h0000, 16'h0100));
      send_request(make_store(8'd5, 16'h0800, 16'h2000, 16'h0200));
      send_request(make_store(8'd6, 16'h0800, 16'hE000, 16'h0300));
      send_request(make_store(8'd7, 16'h0010, 16'hFFF0, 16'h0400));
      send_request(make_eval(16'h1000, 16'h0000, 16'h0000));
      send_request(make_eval(16'h4000, 16'h0400, 16'hA000));
      send_request(make_eval(16'h6000, 16'hF000, 16'h6000));
   endtask

   task automatic test_own_id_and_range();
      write_csr(CSR_OWN_ID, 15'd4);
      write_csr(CSR_RANGE, 15'd0);
      send_request(make_eval(16'h0000, 16'h0000, 16'h0000));
      write_csr(CSR_OWN_ID, 15'd255);
      write_csr(CSR_RANGE, 15'd32767);
      send_request(make_eval(16'h0000, 16'h0000, 16'h2000));
      write_csr(CSR_RANGE, 15'd1);
      send_request(make_eval(16'h1000, 16'hF000, 16'h0000));
      write_csr(CSR_OWN_ID, 15'd16);
      write_csr(CSR_RANGE, 15'd8192);
   endtask

   task automatic test_random(input int count);
      req_type r;
      logic [15:0] px;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 55) begin
            // Mostly valid ids with a bias towards positive x so peers get scanned.
            px = ($urandom_range(3) != 0) ? 16'($urandom_range(16'h7FFF, 1)) : 16'($urandom);
            r = make_store(($urandom_range(9) == 0) ? 8'($urandom)
                           : 8'($urandom_range(NEIGHBOURS, 1)),
                           px, 16'($urandom), 16'($urandom));
            if ($urandom_range(1)) begin
               r.item_y = 16'($signed(16'($urandom_range(16'h3000)))) - 16'sh1800;
               r.item_x = r.item_x[15] ? r.item_x : {2'b00, r.item_x[13:0]};
            end
         end else begin
            r = make_eval(16'($urandom), 16'($urandom), 16'($urandom));
            if ($urandom_range(1)) r.item_x = 16'($urandom_range(16'h3000));
         end
         send_request(r);
      end
   endtask

   task automatic test_idle_phases();
      int pct [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{29, 29}};
      logic [14:0] ranges [4] = '{15'd2048, 15'd32767, 15'd1, 15'd8192};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = pct[p][0];
         stall_pct = pct[p][1];
         write_csr(CSR_OWN_ID, 15'($urandom_range(20)));
         write_csr(CSR_RANGE, ranges[p]);
         test_random(60);
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < NEIGHBOURS; i++) mdl_alive[i] = 1'b0;
      mdl_own_id = 8'd0;
      mdl_range = 15'd8192;
      mdl_prior = 16'd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      running = 1'b1;
      test_empty_and_extremes();
      stall_pct = 30;
      test_sectors_and_back_gap();
      stall_pct = 0;
      test_own_id_and_range();
      test_idle_phases();
      drain_results();
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
